FILE: src/hbif_pkg.sv
// Shared constants, types and state codes of the histogram bump interval finder.
`timescale 1ns / 1ps
`default_nettype none
package hbif_pkg;

	localparam int NUM_BINS     = 65536;
	localparam int BIN_W        = $clog2(NUM_BINS);
	localparam int CNT_W        = 32;
	localparam int DIV_W        = 8;
	localparam int IDX_W        = BIN_W + 2;
	localparam int PTS_W        = 3;
	localparam int STEP_CNT_W   = $clog2(BIN_W);

	localparam logic [PTS_W-1:0] MIN_POINTS    = PTS_W'(5);
	localparam logic [BIN_W-1:0] MIN_STEP      = BIN_W'(2);
	localparam logic [CNT_W-1:0] VALLEY_START  = CNT_W'(999999999);
	localparam logic [DIV_W-1:0] DIVISOR_RESET = DIV_W'(2);
	localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(BIN_W - 1);

	typedef enum logic [1:0] {
		ST_RUN,
		ST_DIV,
		ST_LOAD
	} hbif_state_t;

	typedef struct packed {
		logic take;
		logic finish;
		logic div_step;
		logic load;
	} hbif_cmd_t;

endpackage
`default_nettype wire

FILE: src/hbif_ctrl.sv
// Controller: sequences streaming, the final division and the output load.
`timescale 1ns / 1ps
`default_nettype none
module hbif_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              last,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output hbif_pkg::hbif_cmd_t    cmd
);
	import hbif_pkg::*;

	hbif_state_t             state_q, state_nxt;
	logic [STEP_CNT_W-1:0]   step_q;
	logic                    out_valid_q;
	logic                    out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_RUN: begin
				if (in_valid && last) state_nxt = ST_DIV;
			end
			ST_DIV: begin
				if (step_q == LAST_STEP) state_nxt = ST_LOAD;
			end
			ST_LOAD: begin
				if (out_free) state_nxt = ST_RUN;
			end
			default: state_nxt = ST_RUN;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd          = '0;
		unique case (state_q)
			ST_RUN: begin
				in_ready   = 1'b1;
				cmd.take   = in_valid;
				cmd.finish = in_valid && last;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_LOAD: begin
				cmd.load = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.div_step) step_q <= step_q + STEP_CNT_W'(1);
			else              step_q <= '0;
			if (cmd.load)       out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

FILE: src/hbif_dp.sv
// Datapath: point tracking, valley and peak search, divider and output word.
`timescale 1ns / 1ps
`default_nettype none
module hbif_dp (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire hbif_pkg::hbif_cmd_t                    cmd,
	input  wire logic [hbif_pkg::CNT_W-1:0]             count,
	input  wire logic                                   cfg_we,
	input  wire logic [hbif_pkg::DIV_W-1:0]             cfg_wdata,
	output logic signed [hbif_pkg::IDX_W-1:0]           start_index,
	output logic signed [hbif_pkg::IDX_W-1:0]           end_index,
	output logic                                        found
);
	import hbif_pkg::*;

	logic [DIV_W-1:0] divisor_q;

	logic [CNT_W-1:0] prev_q, vval_q, pval_q;
	logic [BIN_W-1:0] bin_q, fnz_q, lp_q, vbin_q, pbin_q;
	logic [PTS_W-1:0] pts_q;
	logic             nz_q, vdone_q, pdone_q;

	logic [CNT_W-1:0] vval_n, pval_n;
	logic [BIN_W-1:0] fnz_n, lp_n, vbin_n, pbin_n;
	logic [PTS_W-1:0] pts_n;
	logic             nz_n, vdone_n, pdone_n;

	logic                    first_bin, is_point, track;
	logic                    v_upd, p_upd, t_vdone, t_pdone;
	logic [CNT_W-1:0]        t_vval, t_pval;
	logic [BIN_W-1:0]        t_vbin, t_pbin, half, step;
	logic signed [BIN_W:0]   vdist, pdist, span, span_neg;

	logic                    fin_found_q, fin_neg_q;
	logic [BIN_W-1:0]        fin_peak_q, fin_start_q, fin_end_q;
	logic [BIN_W-1:0]        quo_q;
	logic [DIV_W-1:0]        rem_q;

	logic [DIV_W-1:0]        dsel;
	logic [DIV_W:0]          rem_sh;
	logic                    ge;
	logic signed [BIN_W:0]   qs;
	logic signed [IDX_W-1:0] qs_x, peak_x;

	assign first_bin = (pts_q == '0);
	assign is_point  = first_bin || (count != prev_q);
	assign track     = is_point && !first_bin && !pdone_q;

	always_comb begin
		v_upd   = !vdone_q && (vval_q >= count);
		t_vval  = v_upd ? count : vval_q;
		t_vbin  = v_upd ? bin_q : vbin_q;
		half    = {1'b0, t_vbin[BIN_W-1:1]};
		step    = (half < MIN_STEP) ? MIN_STEP : half;
		vdist   = $signed({1'b0, bin_q}) - $signed({1'b0, t_vbin});
		t_vdone = vdist >= $signed({1'b0, step});
		p_upd   = t_vdone && (pval_q < count);
		t_pval  = p_upd ? count : pval_q;
		t_pbin  = p_upd ? bin_q : pbin_q;
		pdist   = $signed({1'b0, bin_q}) - $signed({1'b0, t_pbin});
		span    = $signed({1'b0, t_pbin}) - $signed({1'b0, t_vbin});
		t_pdone = t_vdone && (pdist >= span);
	end

	always_comb begin
		vval_n  = track ? t_vval  : vval_q;
		vbin_n  = track ? t_vbin  : vbin_q;
		vdone_n = track ? t_vdone : vdone_q;
		pval_n  = track ? t_pval  : pval_q;
		pbin_n  = track ? t_pbin  : pbin_q;
		pdone_n = track ? t_pdone : pdone_q;
		pts_n   = (is_point && pts_q < MIN_POINTS) ? pts_q + PTS_W'(1) : pts_q;
		lp_n    = is_point ? bin_q : lp_q;
		fnz_n   = fnz_q;
		nz_n    = nz_q;
		if (is_point && !nz_q && count != '0) begin
			fnz_n = bin_q;
			nz_n  = 1'b1;
		end
	end

	assign span_neg = $signed({1'b0, pbin_n}) - $signed({1'b0, vbin_n});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divisor_q <= DIVISOR_RESET;
			prev_q    <= '0;
			bin_q     <= '0;
			pts_q     <= '0;
			fnz_q     <= '0;
			nz_q      <= 1'b0;
			lp_q      <= '0;
			vval_q    <= VALLEY_START;
			vbin_q    <= BIN_W'(1);
			pval_q    <= '0;
			pbin_q    <= BIN_W'(1);
			vdone_q   <= 1'b0;
			pdone_q   <= 1'b0;
		end else begin
			if (cfg_we) divisor_q <= cfg_wdata;
			if (cmd.finish) begin
				prev_q  <= '0;
				bin_q   <= '0;
				pts_q   <= '0;
				fnz_q   <= '0;
				nz_q    <= 1'b0;
				lp_q    <= '0;
				vval_q  <= VALLEY_START;
				vbin_q  <= BIN_W'(1);
				pval_q  <= '0;
				pbin_q  <= BIN_W'(1);
				vdone_q <= 1'b0;
				pdone_q <= 1'b0;
			end else if (cmd.take) begin
				prev_q  <= count;
				bin_q   <= bin_q + BIN_W'(1);
				pts_q   <= pts_n;
				fnz_q   <= fnz_n;
				nz_q    <= nz_n;
				lp_q    <= lp_n;
				vval_q  <= vval_n;
				vbin_q  <= vbin_n;
				pval_q  <= pval_n;
				pbin_q  <= pbin_n;
				vdone_q <= vdone_n;
				pdone_q <= pdone_n;
			end
		end
	end

	// restoring divider over the peak-to-valley magnitude
	assign dsel   = (divisor_q == '0) ? DIV_W'(1) : divisor_q;
	assign rem_sh = {rem_q, quo_q[BIN_W-1]};
	assign ge     = rem_sh >= {1'b0, dsel};

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			fin_found_q <= (pts_n >= MIN_POINTS) && pdone_n;
			fin_neg_q   <= span_neg[BIN_W];
			fin_peak_q  <= pbin_n;
			fin_start_q <= fnz_n;
			fin_end_q   <= lp_n;
			quo_q       <= span_neg[BIN_W] ? BIN_W'(-span_neg) : span_neg[BIN_W-1:0];
			rem_q       <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? DIV_W'(rem_sh - {1'b0, dsel}) : rem_sh[DIV_W-1:0];
			quo_q <= {quo_q[BIN_W-2:0], ge};
		end
	end

	assign qs     = fin_neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign qs_x   = IDX_W'(qs);
	assign peak_x = $signed({2'b00, fin_peak_q});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (fin_found_q) begin
				start_index <= peak_x - qs_x;
				end_index   <= peak_x + qs_x;
				found       <= 1'b1;
			end else begin
				start_index <= $signed({2'b00, fin_start_q});
				end_index   <= $signed({2'b00, fin_end_q});
				found       <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: src/histogram_bump_interval_finder.sv
// Top level of the histogram bump interval finder.
// Histogram counts stream in one word per cycle while in_ready is high, bin 0 first, with
// last on the final bin. While streaming, a new word is taken every cycle. After the last
// word the block runs a one-bit-per-cycle restoring divider, one step per bin index bit,
// then loads the output register; in_ready stays low until that load is done. The result
// word waits in the output register while the next histogram streams in; the load stalls
// only if the previous result is still untaken. The divisor register may only be written
// while no histogram is in flight.
`timescale 1ns / 1ps
`default_nettype none
module histogram_bump_interval_finder (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [hbif_pkg::DIV_W-1:0]             cfg_wdata,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic [hbif_pkg::CNT_W-1:0]             count,
	input  wire logic                                   last,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic signed [hbif_pkg::IDX_W-1:0]           start_index,
	output logic signed [hbif_pkg::IDX_W-1:0]           end_index,
	output logic                                        found
);
	import hbif_pkg::*;

	hbif_cmd_t cmd;

	hbif_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last      (last),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	hbif_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.count       (count),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.start_index (start_index),
		.end_index   (end_index),
		.found       (found)
	);

endmodule
`default_nettype wire

FILE: bench/tb_histogram_bump_interval_finder.sv
// Self-checking testbench of the histogram bump interval finder: directed and random histograms.
`timescale 1ns / 1ps
module tb_histogram_bump_interval_finder;
	import hbif_pkg::*;

	typedef struct packed {
		logic signed [IDX_W-1:0] start_idx;
		logic signed [IDX_W-1:0] end_idx;
		logic                    hit;
	} interval_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic             lst;
		logic             typed;
		interval_t        want;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [DIV_W-1:0]   cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [CNT_W-1:0]   count = '0;
	logic               last = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [IDX_W-1:0] start_index;
	logic signed [IDX_W-1:0] end_index;
	logic               found;

	logic [CNT_W-1:0]   prev_cnt;
	logic [BIN_W-1:0]   bin_pos;
	logic [PTS_W-1:0]   pts;
	logic [BIN_W-1:0]   first_nz;
	logic               nz_seen;
	logic [BIN_W-1:0]   last_pt;
	logic [CNT_W-1:0]   val_v;
	logic [BIN_W-1:0]   val_b;
	logic [CNT_W-1:0]   pk_v;
	logic [BIN_W-1:0]   pk_b;
	logic               val_done;
	logic               pk_done;
	logic [DIV_W-1:0]   divisor_q;

	interval_t          interval_q[$];
	logic [CNT_W-1:0]   shape_q[$];
	int unsigned        words_sent = 0;
	int unsigned        results_seen = 0;
	int unsigned        err_count = 0;
	bit                 held = 1'b0;

	stim_row_t dir_rows [0:22] = '{
		'{32'd0,          1'b1, 1'b1, '{18'sd0, 18'sd0, 1'b0}},
		'{32'hFFFF_FFFF,  1'b1, 1'b1, '{18'sd0, 18'sd0, 1'b0}},
		'{32'd0,          1'b0, 1'b0, '0},
		'{32'd5,          1'b1, 1'b1, '{18'sd1, 18'sd1, 1'b0}},
		'{32'd10,         1'b0, 1'b0, '0},
		'{32'd3,          1'b0, 1'b0, '0},
		'{32'd2,          1'b0, 1'b0, '0},
		'{32'd1,          1'b0, 1'b0, '0},
		'{32'd2,          1'b0, 1'b0, '0},
		'{32'd5,          1'b0, 1'b0, '0},
		'{32'd9,          1'b0, 1'b0, '0},
		'{32'd4,          1'b0, 1'b0, '0},
		'{32'd3,          1'b0, 1'b0, '0},
		'{32'd2,          1'b0, 1'b0, '0},
		'{32'd1,          1'b1, 1'b0, '0},
		'{32'd7,          1'b0, 1'b0, '0},
		'{32'd7,          1'b0, 1'b0, '0},
		'{32'd7,          1'b0, 1'b0, '0},
		'{32'd7,          1'b1, 1'b1, '{18'sd0, 18'sd0, 1'b0}},
		'{32'd0,          1'b0, 1'b0, '0},
		'{32'hFFFF_FFFF,  1'b0, 1'b0, '0},
		'{32'd0,          1'b0, 1'b0, '0},
		'{32'd1,          1'b1, 1'b0, '0}
	};

	logic [DIV_W-1:0] div_plan [0:4] = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd2};

	histogram_bump_interval_finder i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.count       (count),
		.last        (last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.start_index (start_index),
		.end_index   (end_index),
		.found       (found)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void clear_tracking();
		prev_cnt = '0;
		bin_pos  = '0;
		pts      = '0;
		first_nz = '0;
		nz_seen  = 1'b0;
		last_pt  = '0;
		val_v    = VALLEY_START;
		val_b    = BIN_W'(1);
		pk_v     = '0;
		pk_b     = BIN_W'(1);
		val_done = 1'b0;
		pk_done  = 1'b0;
	endfunction

	function automatic bit predict_interval(input logic [CNT_W-1:0] c, input logic l,
			output interval_t r);
		logic [BIN_W-1:0] b;
		logic [BIN_W-1:0] stride;
		bit first_bin;
		int bi;
		int vi;
		int pi;
		int si;
		int dv;
		int q;
		b = bin_pos;
		first_bin = (pts == '0);
		r = '0;
		if (first_bin || c != prev_cnt) begin
			if (!first_bin && !pk_done) begin
				if (!val_done && val_v >= c) begin
					val_v = c;
					val_b = b;
				end
				stride = ((val_b >> 1) < MIN_STEP) ? MIN_STEP : (val_b >> 1);
				bi = b;
				vi = val_b;
				si = stride;
				val_done = (bi - vi) >= si;
				if (val_done && pk_v < c) begin
					pk_v = c;
					pk_b = b;
				end
				pi = pk_b;
				pk_done = val_done && ((bi - pi) >= (pi - vi));
			end
			if (pts < MIN_POINTS)
				pts = pts + 1'b1;
			last_pt = b;
			if (!nz_seen && c > 0) begin
				first_nz = b;
				nz_seen = 1'b1;
			end
		end
		prev_cnt = c;
		bin_pos = b + 1'b1;
		if (!l)
			return 1'b0;
		if (pts >= MIN_POINTS && pk_done) begin
			pi = pk_b;
			vi = val_b;
			dv = divisor_q;
			if (dv == 0)
				dv = 1;
			q = (pi - vi) / dv;
			r.start_idx = IDX_W'(pi - q);
			r.end_idx   = IDX_W'(pi + q);
			r.hit       = 1'b1;
		end else begin
			r.start_idx = IDX_W'(first_nz);
			r.end_idx   = IDX_W'(last_pt);
			r.hit       = 1'b0;
		end
		clear_tracking();
		return 1'b1;
	endfunction

	function automatic void push_level(input int lvl, input logic [CNT_W-1:0] scale,
			input logic [CNT_W-1:0] base);
		int unsigned reps;
		reps = $urandom_range(1, 3);
		repeat (reps) shape_q = {shape_q, base + CNT_W'(lvl) * scale};
	endfunction

	task automatic send_word(input logic [CNT_W-1:0] c, input logic l, input logic typed,
			input interval_t want);
		interval_t r;
		bit quiet;
		quiet = (words_sent >= 200 && words_sent < 400);
		while (!quiet && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		count    <= c;
		last     <= l;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_sent++;
		if (predict_interval(c, l, r))
			interval_q = {interval_q, typed ? want : r};
	endtask

	initial begin
		int unsigned phase;
		int unsigned target;
		int unsigned kind;
		int lvl;
		int delta;
		logic [CNT_W-1:0] scale;
		logic [CNT_W-1:0] base;
		logic [CNT_W-1:0] pick;
		logic [DIV_W-1:0] div_v;
		clear_tracking();
		divisor_q = DIVISOR_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i])
			send_word(dir_rows[i].cnt, dir_rows[i].lst, dir_rows[i].typed, dir_rows[i].want);
		for (phase = 0; phase < 5; phase++) begin
			in_valid <= 1'b0;
			while (interval_q.size() != 0)
				@(posedge clk);
			repeat (30) @(posedge clk);
			div_v = (phase == 3) ? DIV_W'($urandom_range(3, 254)) : div_plan[phase];
			cfg_we    <= 1'b1;
			cfg_wdata <= div_v;
			@(posedge clk);
			cfg_we <= 1'b0;
			divisor_q = div_v;
			target = words_sent + 150;
			while (words_sent < target) begin
				shape_q.delete();
				kind  = $urandom_range(9);
				scale = CNT_W'(1) << $urandom_range(0, 24);
				base  = $urandom_range(0, 1000);
				lvl   = $urandom_range(20, 60);
				case (kind)
					0: begin
						repeat ($urandom_range(1, 12)) begin
							pick = $urandom_range(1) ? $urandom : $urandom_range(3);
							shape_q = {shape_q, pick};
						end
					end
					1: begin
						delta = int'($urandom_range(0, 2)) - 1;
						repeat ($urandom_range(1, 20)) begin
							push_level(lvl, scale, base);
							lvl += delta;
						end
					end
					default: begin
						push_level(lvl, scale, base);
						repeat ($urandom_range(1, 6)) begin
							lvl -= int'($urandom_range(1, 5));
							if (lvl < 0)
								lvl = 0;
							push_level(lvl, scale, base);
						end
						repeat ($urandom_range(2, 10)) begin
							lvl += int'($urandom_range(1, 6));
							push_level(lvl, scale, base);
						end
						repeat ($urandom_range(2, 15)) begin
							lvl -= int'($urandom_range(1, 4));
							if (lvl < 0)
								lvl = 0;
							push_level(lvl, scale, base);
						end
					end
				endcase
				foreach (shape_q[k])
					send_word(shape_q[k], k == shape_q.size() - 1, 1'b0, '0);
			end
		end
		in_valid <= 1'b0;
		for (int i = 0; i < 5000 && interval_q.size() != 0; i++)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (interval_q.size() != 0) begin
			$error("%0d result words never arrived", interval_q.size());
			err_count++;
		end
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		interval_t want;
		wait (arst_n === 1'b1);
		forever begin
			if (!held && results_seen == 12) begin
				// hold off so the block backs up into its input
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				held = 1'b1;
			end
			out_ready <= (results_seen >= 20 && results_seen < 36) || ($urandom_range(99) >= 9);
			@(posedge clk);
			if (out_valid && out_ready) begin
				results_seen++;
				if (interval_q.size() == 0) begin
					$error("unexpected result word: start_index %0d end_index %0d found %0d",
						start_index, end_index, found);
					err_count++;
				end else begin
					want = interval_q.pop_front();
					if (start_index !== want.start_idx) begin
						$error("start_index: expected %0d, got %0d", want.start_idx, start_index);
						err_count++;
					end
					if (end_index !== want.end_idx) begin
						$error("end_index: expected %0d, got %0d", want.end_idx, end_index);
						err_count++;
					end
					if (found !== want.hit) begin
						$error("found: expected %0d, got %0d", want.hit, found);
						err_count++;
					end
				end
			end
		end
	end

	initial begin
		#8_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
